/* sv/time_ordered_wait_queue_macros.svh */
// ---------------------------------------------------------------------------
// time_ordered_wait_queue_macros
// Assertion macros used by the wait queue top module.
// ---------------------------------------------------------------------------
`ifndef TIME_ORDERED_WAIT_QUEUE_MACROS_SVH
`define TIME_ORDERED_WAIT_QUEUE_MACROS_SVH

// property checked outside of reset
`define TOWQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wait queue check failed");

// property checked on every edge, reset included
`define TOWQ_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wait queue reset check failed");

`endif

/* sv/towq_pkg.sv */
// ---------------------------------------------------------------------------
// towq_pkg
// Field widths, opcodes, status codes, divide-by-100 constants and cell control for the wait queue.
// ---------------------------------------------------------------------------
package towq_pkg;

  localparam int KEY_W  = 12;
  localparam int TAG_W  = 8;
  localparam int STAT_W = 2;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 7;
  localparam int OCC_W  = 4;

  // time / 100 as (time * 5243) >> 19, exact for any 12-bit time
  localparam int QUOT_W       = 6;
  localparam int DIV100_SHIFT = 19;
  localparam int MUL_W        = 25;
  localparam logic [MUL_W-1:0] DIV100_MUL = MUL_W'(5243);
  localparam logic [KEY_W-1:0] DEC_BASE   = KEY_W'(100);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

/* sv/towq_if.sv */
// ---------------------------------------------------------------------------
// towq_if
// Request and result channels of the wait queue, valid/ready handshake.
// ---------------------------------------------------------------------------
interface towq_in_if import towq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [KEY_W-1:0] arrival_time;
  logic [TAG_W-1:0] customer_tag;

  modport source (output valid, op, arrival_time, customer_tag, input ready);
  modport sink   (input valid, op, arrival_time, customer_tag, output ready);
endinterface

interface towq_out_if import towq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  head_tag;
  logic [HOUR_W-1:0] head_hours;
  logic [MIN_W-1:0]  head_minutes;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, head_tag, head_hours, head_minutes, occupancy,
                  input ready);
  modport sink   (input valid, status, head_tag, head_hours, head_minutes, occupancy,
                  output ready);
endinterface

/* sv/towq_cell.sv */
// ---------------------------------------------------------------------------
// towq_cell
// One slot of the sorted chain: holds a key and tag, shifts toward the tail
// on an insert ahead of it and toward the head on a remove.
// ---------------------------------------------------------------------------
module towq_cell import towq_pkg::*; #(
  parameter int TAG_BITS = 8
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                occupied,
  input  logic [KEY_W-1:0]    new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                left_gt,
  input  logic [KEY_W-1:0]    left_key,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic [KEY_W-1:0]    right_key,
  input  logic [TAG_BITS-1:0] right_tag,
  output logic [KEY_W-1:0]    key,
  output logic [TAG_BITS-1:0] tag,
  output logic                gt
);

  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  // stored entry sorts strictly after the new one
  assign gt = occupied && (key_r > new_key);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.insert) begin
      if (left_gt) begin
        key_nxt = left_key;
        tag_nxt = left_tag;
      end else if (gt || !occupied) begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end else if (ctrl.remove) begin
      key_nxt = right_key;
      tag_nxt = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

/* sv/time_ordered_wait_queue.sv */
// ---------------------------------------------------------------------------
// time_ordered_wait_queue
// Bounded queue kept in ascending hhmm order by a chain of insert/shift
// cells; removes hand back the head split into hours and minutes.
// ---------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_chan   in   valid / ready   op, arrival_time, customer_tag
//  out_chan  out  valid / ready   status, head_tag, head_hours, head_minutes, occupancy
//
//  one item per cycle while out_chan is not stalled: every cell picks its next value
//  from its neighbors and registers it when an insert or remove is carried out
//  results sit in an output register; input is taken while it is empty or drained
//  synchronous active-low reset clears the count and the output valid only
//  a stalled result holds the input off until out_chan.ready returns
// ---------------------------------------------------------------------------
module time_ordered_wait_queue import towq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  parameter int TAG_BITS    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  towq_in_if.sink    in_chan,
  towq_out_if.source out_chan
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [QUOT_W-1:0]   quot_r, quot_nxt;
  logic [KEY_W-1:0]    time_r, time_nxt;
  logic [OCC_W-1:0]    occ_r;

  logic                accept, full, empty, do_ins, do_rem;
  cell_ctrl_t          ctrl;
  logic [TAG_BITS-1:0] new_tag;
  logic [MUL_W-1:0]    prod;
  logic [KEY_W-1:0]    quot_x100;

  logic [KEY_W-1:0]    key_w [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_w [QUEUE_DEPTH];
  logic                gt_w  [QUEUE_DEPTH];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty         = (count_r == '0);
  assign do_ins        = accept && (in_chan.op == OP_INSERT) && !full;
  assign do_rem        = accept && (in_chan.op == OP_REMOVE) && !empty;
  assign ctrl.insert   = do_ins;
  assign ctrl.remove   = do_rem;
  assign new_tag       = TAG_BITS'(in_chan.customer_tag);

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                left_gt;
    logic [KEY_W-1:0]    left_key, right_key;
    logic [TAG_BITS-1:0] left_tag, right_tag;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_key = in_chan.arrival_time;
      assign left_tag = new_tag;
    end else begin : g_mid
      assign left_gt  = gt_w[i-1];
      assign left_key = key_w[i-1];
      assign left_tag = tag_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_key = key_w[i];
      assign right_tag = tag_w[i];
    end else begin : g_body
      assign right_key = key_w[i+1];
      assign right_tag = tag_w[i+1];
    end

    towq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < count_r),
      .new_key   (in_chan.arrival_time),
      .new_tag   (new_tag),
      .left_gt   (left_gt),
      .left_key  (left_key),
      .left_tag  (left_tag),
      .right_key (right_key),
      .right_tag (right_tag),
      .key       (key_w[i]),
      .tag       (tag_w[i]),
      .gt        (gt_w[i])
    );
  end

  // head time / 100 by reciprocal multiply
  assign prod = MUL_W'(key_w[0]) * DIV100_MUL;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_INSERTED;
    tag_nxt    = '0;
    quot_nxt   = '0;
    time_nxt   = '0;
    if (in_chan.op == OP_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_REMOVED;
        count_nxt  = count_r - CNT_W'(1);
        tag_nxt    = TAG_W'(tag_w[0]);
        quot_nxt   = prod[DIV100_SHIFT +: QUOT_W];
        time_nxt   = key_w[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      tag_r    <= tag_nxt;
      quot_r   <= quot_nxt;
      time_r   <= time_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  // remainder from the registered quotient
  assign quot_x100 = KEY_W'(quot_r) * DEC_BASE;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.head_tag     = tag_r;
  assign out_chan.head_hours   = quot_r[HOUR_W-1:0];
  assign out_chan.head_minutes = MIN_W'(time_r - quot_x100);
  assign out_chan.occupancy    = occ_r;

`include "time_ordered_wait_queue_macros.svh"

  `TOWQ_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `TOWQ_ASSERT(a_full_reject, (accept && in_chan.op == OP_INSERT && full) |=>
    (out_valid_r && status_r == ST_FULL && count_r == $past(count_r)))
  `TOWQ_ASSERT(a_remove_count, do_rem |=> (count_r == $past(count_r) - CNT_W'(1)))
  `TOWQ_ASSERT_ANY(a_reset_idle, !rst_n |=> (!out_valid_r && count_r == '0))

endmodule
